/* hw/rtl/sri_pkg.sv */
// shared widths and types for the segment versus rectangle intersection pipeline
package sri_pkg;

    localparam int CB         = 16;
    localparam int LEN_W      = CB - 1;
    localparam int E_W        = CB + 1;
    localparam int D_W        = CB + 1;
    localparam int A_W        = CB + 2;
    localparam int MAG_W      = CB + 1;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int QB         = CB + 2;
    localparam int REM_W      = CB + 1;
    localparam int STEPS      = 2;
    localparam int DIV_STAGES = (QB + STEPS - 1) / STEPS;
    localparam int V_W        = QB + 3;
    localparam int LAT        = 2 + DIV_STAGES;
    localparam int NUM_EDGES  = 4;

    localparam int EDGE_RIGHT = 0;
    localparam int EDGE_LOW   = 1;
    localparam int EDGE_LEFT  = 2;
    localparam int EDGE_HIGH  = 3;

    typedef struct packed {
        logic                    ok;
        logic                    negp;
        logic                    negd;
        logic signed [CB-1:0]    v1;
        logic signed [CB-1:0]    lo;
        logic [LEN_W-1:0]        len;
        logic [CB-1:0]           e;
    } t_side;

endpackage

/* hw/rtl/sri_lane.sv */
// one edge test: range check, product, pipelined long division, final bound check
module sri_lane (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [sri_pkg::CB-1:0]      i_u1,
    input  logic signed [sri_pkg::CB-1:0]      i_v1,
    input  logic signed [sri_pkg::CB-1:0]      i_u2,
    input  logic signed [sri_pkg::CB-1:0]      i_v2,
    input  logic signed [sri_pkg::E_W-1:0]     i_e,
    input  logic signed [sri_pkg::CB-1:0]      i_lo,
    input  logic [sri_pkg::LEN_W-1:0]          i_len,
    output logic                               o_hit,
    output logic signed [sri_pkg::CB-1:0]      o_hv,
    output logic [sri_pkg::CB-1:0]             o_e
);

    localparam int QB    = sri_pkg::QB;
    localparam int REM_W = sri_pkg::REM_W;
    localparam int MAG_W = sri_pkg::MAG_W;
    localparam int NS    = sri_pkg::DIV_STAGES;

    // range check stage
    logic signed [sri_pkg::D_W-1:0] du, dv;
    logic signed [sri_pkg::A_W-1:0] a, du_a;
    logic                           a_in;
    sri_pkg::t_side                 n_side1;
    logic [MAG_W-1:0]               n_ma, n_mdv, n_mdu;

    always_comb begin
        du   = sri_pkg::D_W'(i_u2) - sri_pkg::D_W'(i_u1);
        dv   = sri_pkg::D_W'(i_v2) - sri_pkg::D_W'(i_v1);
        a    = sri_pkg::A_W'(i_e) - sri_pkg::A_W'(i_u1);
        du_a = sri_pkg::A_W'(du);
        if (!du[sri_pkg::D_W-1]) begin
            a_in = !a[sri_pkg::A_W-1] && (a <= du_a);
        end else begin
            a_in = (a <= 0) && (a >= du_a);
        end
        n_side1.ok   = (i_len != '0) && (du != '0) && a_in;
        n_side1.negp = a[sri_pkg::A_W-1] != dv[sri_pkg::D_W-1];
        n_side1.negd = du[sri_pkg::D_W-1];
        n_side1.v1   = i_v1;
        n_side1.lo   = i_lo;
        n_side1.len  = i_len;
        n_side1.e    = i_e[sri_pkg::CB-1:0];
        n_ma  = a[sri_pkg::A_W-1] ? MAG_W'(-a) : MAG_W'(a);
        n_mdv = dv[sri_pkg::D_W-1] ? MAG_W'(-dv) : MAG_W'(dv);
        n_mdu = du[sri_pkg::D_W-1] ? MAG_W'(-du) : MAG_W'(du);
    end

    sri_pkg::t_side                 r_side1, r_side2;
    logic [MAG_W-1:0]               r_ma, r_mdv, r_mdu, r_mdu2;
    logic [sri_pkg::PROD_W-1:0]     r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= n_side1;
            r_ma    <= n_ma;
            r_mdv   <= n_mdv;
            r_mdu   <= n_mdu;
            r_side2 <= r_side1;
            r_mdu2  <= r_mdu;
            r_prod  <= sri_pkg::PROD_W'(r_ma) * sri_pkg::PROD_W'(r_mdv);
        end
    end

    // division stages
    sri_pkg::t_side   r_side [NS];
    logic [MAG_W-1:0] r_d    [NS];
    logic [REM_W-1:0] r_rem  [NS];
    logic [QB-1:0]    r_num  [NS];
    logic [QB-1:0]    r_q    [NS];

    for (genvar s = 0; s < NS; s++) begin : g_div
        sri_pkg::t_side   side_in;
        logic [MAG_W-1:0] d_in;
        logic [REM_W-1:0] rem_in;
        logic [QB-1:0]    num_in, q_in;
        logic [REM_W-1:0] n_rem;
        logic [QB-1:0]    n_num, n_q;
        logic [REM_W:0]   t;

        if (s == 0) begin : g_first
            assign side_in = r_side2;
            assign d_in    = r_mdu2;
            assign rem_in  = REM_W'(r_prod[sri_pkg::PROD_W-1:QB]);
            assign num_in  = r_prod[QB-1:0];
            assign q_in    = '0;
        end else begin : g_next
            assign side_in = r_side[s-1];
            assign d_in    = r_d[s-1];
            assign rem_in  = r_rem[s-1];
            assign num_in  = r_num[s-1];
            assign q_in    = r_q[s-1];
        end

        always_comb begin
            n_rem = rem_in;
            n_num = num_in;
            n_q   = q_in;
            t     = '0;
            for (int k = 0; k < sri_pkg::STEPS; k++) begin
                if (s * sri_pkg::STEPS + k < QB) begin
                    t     = {n_rem, n_num[QB-1]};
                    n_num = {n_num[QB-2:0], 1'b0};
                    if (t >= (REM_W+1)'(d_in)) begin
                        t   = t - (REM_W+1)'(d_in);
                        n_q = {n_q[QB-2:0], 1'b1};
                    end else begin
                        n_q = {n_q[QB-2:0], 1'b0};
                    end
                    n_rem = t[REM_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s] <= side_in;
                r_d[s]    <= d_in;
                r_rem[s]  <= n_rem;
                r_num[s]  <= n_num;
                r_q[s]    <= n_q;
            end
        end
    end

    // sign, offset and bound check
    sri_pkg::t_side                 fs;
    logic signed [sri_pkg::V_W-1:0] q, v, hv, len_v;
    logic                           negq, fz, fp, ok_lo, ok_hi;

    always_comb begin
        fs    = r_side[NS-1];
        negq  = fs.negp != fs.negd;
        q     = negq ? -$signed(sri_pkg::V_W'(r_q[NS-1])) : $signed(sri_pkg::V_W'(r_q[NS-1]));
        fz    = r_rem[NS-1] == '0;
        fp    = !fz && (fs.negp == fs.negd);
        hv    = sri_pkg::V_W'(fs.v1) + q;
        v     = hv - sri_pkg::V_W'(fs.lo);
        len_v = $signed(sri_pkg::V_W'(fs.len));
        ok_lo = (v >= 1) || (v == 0 && (fz || fp));
        ok_hi = (v <= len_v - 1) || (v == len_v && !fp);
        o_hit = fs.ok && ok_lo && ok_hi;
        o_hv  = hv[sri_pkg::CB-1:0];
        o_e   = fs.e;
    end

endmodule

/* hw/rtl/segment_rectangle_intersect.sv */
// top level: an edge lane for each side of the rectangle, valid pipeline and output register
//
//  channel | valid   | ready   | payload
//  request | i_valid | o_ready | i_start_x .. i_rect_height
//  result  | o_valid | i_ready | o_hit_mask, o_any_hit, o_*_hit_x/y
//
// one request per cycle while no result is stalled; each request passes through these stages
// (range check, product, nine two-bit division stages, output register)
// reset clears all valid bits; no result is pending after reset
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
module segment_rectangle_intersect (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [15:0]            i_start_x,
    input  logic signed [15:0]            i_start_y,
    input  logic signed [15:0]            i_end_x,
    input  logic signed [15:0]            i_end_y,
    input  logic signed [15:0]            i_rect_left,
    input  logic signed [15:0]            i_rect_bottom,
    input  logic [14:0]                   i_rect_width,
    input  logic [14:0]                   i_rect_height,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [3:0]                    o_hit_mask,
    output logic                          o_any_hit,
    output logic signed [15:0]            o_right_hit_x,
    output logic signed [15:0]            o_right_hit_y,
    output logic signed [15:0]            o_low_hit_x,
    output logic signed [15:0]            o_low_hit_y,
    output logic signed [15:0]            o_left_hit_x,
    output logic signed [15:0]            o_left_hit_y,
    output logic signed [15:0]            o_high_hit_x,
    output logic signed [15:0]            o_high_hit_y
);

    localparam int CB  = sri_pkg::CB;
    localparam int E_W = sri_pkg::E_W;
    localparam int NE  = sri_pkg::NUM_EDGES;

    logic                  en;
    logic                  r_vld [sri_pkg::LAT];
    logic                  r_out_valid;
    logic [NE-1:0]         hit;
    logic signed [CB-1:0]  hv [NE];
    logic [CB-1:0]         ev [NE];
    logic signed [E_W-1:0] e_right, e_low, e_left, e_high;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_out_valid;

    assign e_right = E_W'(i_rect_left) + $signed(E_W'(i_rect_width));
    assign e_low   = E_W'(i_rect_bottom);
    assign e_left  = E_W'(i_rect_left);
    assign e_high  = E_W'(i_rect_bottom) + $signed(E_W'(i_rect_height));

    sri_lane u_right (
        .i_clk(i_clk), .i_en(en),
        .i_u1(i_start_x), .i_v1(i_start_y), .i_u2(i_end_x), .i_v2(i_end_y),
        .i_e(e_right), .i_lo(i_rect_bottom), .i_len(i_rect_height),
        .o_hit(hit[sri_pkg::EDGE_RIGHT]), .o_hv(hv[sri_pkg::EDGE_RIGHT]),
        .o_e(ev[sri_pkg::EDGE_RIGHT])
    );

    sri_lane u_low (
        .i_clk(i_clk), .i_en(en),
        .i_u1(i_start_y), .i_v1(i_start_x), .i_u2(i_end_y), .i_v2(i_end_x),
        .i_e(e_low), .i_lo(i_rect_left), .i_len(i_rect_width),
        .o_hit(hit[sri_pkg::EDGE_LOW]), .o_hv(hv[sri_pkg::EDGE_LOW]),
        .o_e(ev[sri_pkg::EDGE_LOW])
    );

    sri_lane u_left (
        .i_clk(i_clk), .i_en(en),
        .i_u1(i_start_x), .i_v1(i_start_y), .i_u2(i_end_x), .i_v2(i_end_y),
        .i_e(e_left), .i_lo(i_rect_bottom), .i_len(i_rect_height),
        .o_hit(hit[sri_pkg::EDGE_LEFT]), .o_hv(hv[sri_pkg::EDGE_LEFT]),
        .o_e(ev[sri_pkg::EDGE_LEFT])
    );

    sri_lane u_high (
        .i_clk(i_clk), .i_en(en),
        .i_u1(i_start_y), .i_v1(i_start_x), .i_u2(i_end_y), .i_v2(i_end_x),
        .i_e(e_high), .i_lo(i_rect_left), .i_len(i_rect_width),
        .o_hit(hit[sri_pkg::EDGE_HIGH]), .o_hv(hv[sri_pkg::EDGE_HIGH]),
        .o_e(ev[sri_pkg::EDGE_HIGH])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sri_pkg::LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < sri_pkg::LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_out_valid <= r_vld[sri_pkg::LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_hit_mask    <= hit;
            o_any_hit     <= |hit;
            o_right_hit_x <= hit[sri_pkg::EDGE_RIGHT] ? $signed(ev[sri_pkg::EDGE_RIGHT]) : '0;
            o_right_hit_y <= hit[sri_pkg::EDGE_RIGHT] ? hv[sri_pkg::EDGE_RIGHT] : '0;
            o_low_hit_x   <= hit[sri_pkg::EDGE_LOW] ? hv[sri_pkg::EDGE_LOW] : '0;
            o_low_hit_y   <= hit[sri_pkg::EDGE_LOW] ? $signed(ev[sri_pkg::EDGE_LOW]) : '0;
            o_left_hit_x  <= hit[sri_pkg::EDGE_LEFT] ? $signed(ev[sri_pkg::EDGE_LEFT]) : '0;
            o_left_hit_y  <= hit[sri_pkg::EDGE_LEFT] ? hv[sri_pkg::EDGE_LEFT] : '0;
            o_high_hit_x  <= hit[sri_pkg::EDGE_HIGH] ? hv[sri_pkg::EDGE_HIGH] : '0;
            o_high_hit_y  <= hit[sri_pkg::EDGE_HIGH] ? $signed(ev[sri_pkg::EDGE_HIGH]) : '0;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_miss_zero_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit_mask[0] && !o_hit_mask[2] |->
            o_right_hit_x == 0 && o_right_hit_y == 0 && o_left_hit_x == 0 && o_left_hit_y == 0)
        else $error("missed vertical edge reports a point");

    a_miss_zero_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit_mask[1] && !o_hit_mask[3] |->
            o_low_hit_x == 0 && o_low_hit_y == 0 && o_high_hit_x == 0 && o_high_hit_y == 0)
        else $error("missed horizontal edge reports a point");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hit_mask) && !$past(o_ready))
        else $error("stalled result changed");

endmodule

/* bench/segment_rectangle_intersect_test.sv */
// testbench for the segment versus rectangle intersection block with a scoreboard class
`timescale 1ns / 1ps

module segment_rectangle_intersect_test;

    typedef struct {
        logic [3:0]         mask;
        logic               any;
        logic signed [15:0] px [sri_pkg::NUM_EDGES];
        logic signed [15:0] py [sri_pkg::NUM_EDGES];
    } t_hit_result;

    // crossing test for one edge; exact through 64-bit integers
    function automatic bit cross_edge(longint u1, longint du, longint v1, longint dv,
                                      longint e, longint lo, longint len,
                                      output longint hv);
        longint a, prod, q, r, v;
        bit frac_pos;
        hv = 0;
        if (len == 0 || du == 0) return 0;
        a = e - u1;
        if (du > 0) begin
            if (a < 0 || a > du) return 0;
        end else begin
            if (a > 0 || a < du) return 0;
        end
        prod = a * dv;
        q = prod / du;
        r = prod % du;
        frac_pos = (r != 0) && ((prod < 0) == (du < 0));
        v = v1 + q - lo;
        if (!((v >= 1) || (v == 0 && (r == 0 || frac_pos)))) return 0;
        if (!((v <= len - 1) || (v == len && !frac_pos))) return 0;
        hv = v1 + q;
        return 1;
    endfunction

    class t_hit_scoreboard;
        t_hit_result pending[$];
        int errors = 0;

        function void note_request(longint x1, longint y1, longint x2, longint y2,
                                   longint rx, longint ry, longint w, longint h);
            t_hit_result res;
            longint dx, dy, t;
            dx = x2 - x1;
            dy = y2 - y1;
            res.mask = '0;
            for (int k = 0; k < sri_pkg::NUM_EDGES; k++) begin
                res.px[k] = '0;
                res.py[k] = '0;
            end
            if (cross_edge(x1, dx, y1, dy, rx + w, ry, h, t)) begin
                res.mask[sri_pkg::EDGE_RIGHT] = 1'b1;
                res.px[sri_pkg::EDGE_RIGHT] = 16'(rx + w);
                res.py[sri_pkg::EDGE_RIGHT] = 16'(t);
            end
            if (cross_edge(y1, dy, x1, dx, ry, rx, w, t)) begin
                res.mask[sri_pkg::EDGE_LOW] = 1'b1;
                res.px[sri_pkg::EDGE_LOW] = 16'(t);
                res.py[sri_pkg::EDGE_LOW] = 16'(ry);
            end
            if (cross_edge(x1, dx, y1, dy, rx, ry, h, t)) begin
                res.mask[sri_pkg::EDGE_LEFT] = 1'b1;
                res.px[sri_pkg::EDGE_LEFT] = 16'(rx);
                res.py[sri_pkg::EDGE_LEFT] = 16'(t);
            end
            if (cross_edge(y1, dy, x1, dx, ry + h, rx, w, t)) begin
                res.mask[sri_pkg::EDGE_HIGH] = 1'b1;
                res.px[sri_pkg::EDGE_HIGH] = 16'(t);
                res.py[sri_pkg::EDGE_HIGH] = 16'(ry + h);
            end
            res.any = (res.mask != '0);
            pending.push_back(res);
        endfunction

        function void check_result(t_hit_result got);
            t_hit_result exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result mask %h", $time, got.mask);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.mask !== exp.mask) begin
                $display("%0t: hit_mask expected %h actual %h", $time, exp.mask, got.mask);
                errors++;
            end
            if (got.any !== exp.any) begin
                $display("%0t: any_hit expected %b actual %b", $time, exp.any, got.any);
                errors++;
            end
            for (int k = 0; k < sri_pkg::NUM_EDGES; k++) begin
                if (got.px[k] !== exp.px[k] || got.py[k] !== exp.py[k]) begin
                    $display("%0t: edge %0d point expected (%0d,%0d) actual (%0d,%0d)",
                             $time, k, exp.px[k], exp.py[k], got.px[k], got.py[k]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_ready = 0;
    logic o_ready, o_valid, o_any_hit;
    logic [3:0] o_hit_mask;
    logic signed [15:0] i_start_x = 0, i_start_y = 0, i_end_x = 0, i_end_y = 0;
    logic signed [15:0] i_rect_left = 0, i_rect_bottom = 0;
    logic [14:0] i_rect_width = 0, i_rect_height = 0;
    logic signed [15:0] o_right_hit_x, o_right_hit_y, o_low_hit_x, o_low_hit_y;
    logic signed [15:0] o_left_hit_x, o_left_hit_y, o_high_hit_x, o_high_hit_y;

    t_hit_scoreboard board = new();
    int cycles = 0;
    bit sending_done = 0;

    always #4 i_clk = ~i_clk;

    segment_rectangle_intersect DUT (.*);

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(longint x1, longint y1, longint x2, longint y2,
                                longint rx, longint ry, longint w, longint h);
        repeat (gap_length()) @(negedge i_clk);
        i_start_x = 16'(x1); i_start_y = 16'(y1); i_end_x = 16'(x2); i_end_y = 16'(y2);
        i_rect_left = 16'(rx); i_rect_bottom = 16'(ry);
        i_rect_width = 15'(w); i_rect_height = 15'(h);
        i_valid = 1;
        do @(posedge i_clk); while (!o_ready);
        board.note_request(longint'(i_start_x), longint'(i_start_y),
                           longint'(i_end_x), longint'(i_end_y),
                           longint'(i_rect_left), longint'(i_rect_bottom),
                           longint'(i_rect_width), longint'(i_rect_height));
        @(negedge i_clk);
        i_valid = 0;
    endtask

    function automatic longint rand_coord();
        return longint'($signed(16'($urandom)));
    endfunction

    function automatic longint near(longint base, longint span);
        longint v;
        int pick;
        pick = $urandom_range(0, 5);
        case (pick)
            0: v = base;
            1: v = base + span;
            default: v = base - span / 2 - 20
                         + longint'($urandom_range(0, 32'(2 * span + 40)));
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    // segment near the rectangle so that edges are often crossed
    task automatic send_near();
        longint rx, ry, w, h, lim;
        int sz;
        sz = $urandom_range(0, 9);
        lim = (sz == 0) ? 32767 : (sz < 4 ? 2000 : 200);
        w = longint'($urandom_range(0, 32'(lim)));
        h = longint'($urandom_range(0, 32'(lim)));
        rx = longint'($signed(16'($urandom_range(0, 65535))));
        ry = longint'($signed(16'($urandom_range(0, 65535))));
        if (rx + w > 32767) rx = 32767 - w;
        if (ry + h > 32767) ry = 32767 - h;
        send_request(near(rx, w), near(ry, h), near(rx, w), near(ry, h), rx, ry, w, h);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        // extremes, corners, parallel and degenerate cases
        send_request(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
        send_request(32767, 32767, -32768, -32768, 0, 0, 32767, 32767);
        send_request(-32768, 32767, 32767, -32768, -100, -100, 200, 200);
        send_request(0, 0, 0, 0, 0, 0, 16, 16);
        send_request(-16, 0, 32, 0, 0, 0, 16, 16);
        send_request(-16, 0, 32, 0, 0, 0, 0, 16);
        send_request(0, -16, 0, 32, 0, 0, 16, 0);
        send_request(-16, -16, 32, 32, 0, 0, 16, 16);
        send_request(16, 16, -16, -16, 0, 0, 16, 16);
        send_request(-5, 3, 21, 7, 0, 0, 16, 16);
        send_request(7, -9, 3, 25, 0, 0, 16, 16);
        send_request(8, 8, 40, 40, 0, 0, 16, 16);
        send_request(0, 5, 16, 5, 0, 0, 16, 16);
        send_request(-32768, 0, -32768, 100, -32768, 0, 0, 50);
        send_request(32767, 0, -32768, 1, -20000, -5, 32767, 10);
        send_request(-3, -7, 19, 29, 0, 0, 16, 16);
        send_request(16, 0, 32, 16, 0, 0, 16, 16);
        send_request(-16, 17, 32, -1, 0, 0, 16, 16);
        // drain before continuing
        wait (board.pending.size() == 0);
        for (int n = 0; n < 1830; n++) begin
            if (n == 900) wait (board.pending.size() == 0);
            if ($urandom_range(0, 9) < 8) send_near();
            else send_request(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(),
                              longint'($urandom_range(0, 32767)),
                              longint'($urandom_range(0, 32767)));
        end
        sending_done = 1;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) == 0) begin
                i_ready <= 0;
                repeat ($urandom_range(10, 40)) @(negedge i_clk);
                i_ready <= 1;
            end else begin
                i_ready <= ($urandom_range(0, 3) != 0) || (cycles % 3000 > 2500);
            end
        end
    end

    always @(posedge i_clk) begin
        t_hit_result got;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            got.mask = o_hit_mask;
            got.any = o_any_hit;
            got.px[sri_pkg::EDGE_RIGHT] = o_right_hit_x;
            got.py[sri_pkg::EDGE_RIGHT] = o_right_hit_y;
            got.px[sri_pkg::EDGE_LOW]   = o_low_hit_x;
            got.py[sri_pkg::EDGE_LOW]   = o_low_hit_y;
            got.px[sri_pkg::EDGE_LEFT]  = o_left_hit_x;
            got.py[sri_pkg::EDGE_LEFT]  = o_left_hit_y;
            got.px[sri_pkg::EDGE_HIGH]  = o_high_hit_x;
            got.py[sri_pkg::EDGE_HIGH]  = o_high_hit_y;
            board.check_result(got);
        end
    end

    initial begin
        wait (sending_done && board.pending.size() == 0);
        repeat (3 * sri_pkg::LAT) @(posedge i_clk);
        if (board.errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        wait (cycles == 400000);
        $display("%0t: timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
